### design/lsps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsps_pkg
// Shared types, constants and the colour palette of the LED strip pattern
// sequencer.
// ---------------------------------------------------------------------------
package lsps_pkg;

   // strip geometry
   localparam int LED_COUNT  = 8;
   localparam int LED_IDX_W  = 3;
   localparam int PHASE_W    = 4;
   localparam int TICK_W     = 10;
   localparam int WORD_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // period register accepts writes below this limit only
   localparam logic [TICK_W-1:0] PERIOD_LIMIT = 10'd1001;
   localparam logic [TICK_W-1:0] PERIOD_RESET = 10'd1000;

   typedef logic [2:0]          color_code_type;
   typedef logic [WORD_W-1:0]   grb_type;
   typedef logic [LED_IDX_W-1:0] led_idx_type;
   typedef logic [PHASE_W-1:0]  phase_type;

   // pattern modes
   typedef enum logic [1:0] {
      MODE_CONST = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_WAVE  = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_COLOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_COLOR_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_COLOR_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_PERIOD = 3'd4;

   // colour codes
   localparam color_code_type CODE_WHITE = 3'd0;
   localparam color_code_type CODE_BLACK = 3'd1;
   localparam color_code_type CODE_BLUE  = 3'd2;
   localparam color_code_type CODE_RED   = 3'd3;
   localparam color_code_type CODE_GREEN = 3'd4;

   localparam grb_type GRB_WHITE = 24'hFFFFFF;
   localparam grb_type GRB_BLACK = 24'h000000;

   // true for codes that have a palette entry
   function automatic logic color_known(input color_code_type code);
      return (code <= CODE_GREEN);
   endfunction

   // palette lookup, green in the top byte
   function automatic grb_type color_word(input color_code_type code);
      grb_type word;
      unique case (code)
         CODE_WHITE: word = 24'hFFFFFF;
         CODE_BLACK: word = 24'h000000;
         CODE_BLUE:  word = 24'h0000FF;
         CODE_RED:   word = 24'h00FF00;
         CODE_GREEN: word = 24'hFF0000;
         default:    word = 24'h000000;
      endcase
      return word;
   endfunction

endpackage

### design/led_strip_pattern_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_strip_pattern_sequencer
// Counts millisecond ticks, repaints an 8-LED frame store by pattern mode
// every update_period+1 ticks and streams the frame as GRB words.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_advance
//  rsp     | out       | rsp_valid/stall    | rsp_led_index, rsp_grb_word, rsp_last
//  csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
//  a tick beat that causes no update leaves the sequencer idle for the next beat
//  an update beat first latches the update, then paints and streams the LEDs
//  in order through the shared paint unit and the frame store port
//  reset is synchronous; the frame store resets to white, no clearing pass
//  req_stall stays high while the frame is streamed; rsp_stall holds the
//  output register and pauses the sequencer
// ---------------------------------------------------------------------------
module led_strip_pattern_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // tick channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_advance,
   // word channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_led_index,
   output logic [23:0]                     rsp_grb_word,
   output logic                            rsp_last,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [lsps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lsps_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // registers
   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   color_code_type  main_color_ff, main_color_in;
   color_code_type  color_a_ff, color_a_in;
   color_code_type  color_b_ff, color_b_in;
   logic [TICK_W-1:0] period_ff, period_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   phase_type       phase_ff, phase_in;
   grb_type         frame_ff [LED_COUNT];
   led_idx_type     idx_ff, idx_in;
   mode_type        upd_mode_ff, upd_mode_in;
   color_code_type  upd_code_ff, upd_code_in;
   phase_type       upd_pos_ff, upd_pos_in;
   logic            rsp_valid_ff, rsp_valid_in;
   led_idx_type     rsp_idx_ff, rsp_idx_in;
   grb_type         rsp_word_ff, rsp_word_in;
   logic            rsp_last_ff, rsp_last_in;

   logic      req_take;
   logic      do_update;
   logic      load;
   logic      idx_is_last;
   grb_type   old_word;
   grb_type   new_word;
   phase_type wave_pos;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign do_update = req_take && req_advance && (tick_ff >= period_ff);
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign idx_is_last = (idx_ff == led_idx_type'(LED_COUNT - 1));
   assign wave_pos  = (phase_ff >= phase_type'(LED_COUNT)) ? '0 : phase_ff;

   // shared paint unit: new colour of the LED under the sequencer
   always_comb begin
      old_word = frame_ff[idx_ff];
      if (upd_mode_ff == MODE_WAVE) begin
         if (color_known(upd_code_ff) && (phase_type'(idx_ff) == upd_pos_ff)) begin
            new_word = color_word(upd_code_ff);
         end else begin
            new_word = GRB_BLACK;
         end
      end else if (color_known(upd_code_ff)) begin
         new_word = color_word(upd_code_ff);
      end else begin
         new_word = old_word;
      end
   end

   // configuration writes
   always_comb begin
      mode_in       = mode_ff;
      main_color_in = main_color_ff;
      color_a_in    = color_a_ff;
      color_b_in    = color_b_ff;
      period_in     = period_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_MODE:  mode_in       = mode_type'(csr_wdata[1:0]);
            CSR_MAIN_COLOR:    main_color_in = csr_wdata[2:0];
            CSR_BLINK_COLOR_A: color_a_in    = csr_wdata[2:0];
            CSR_BLINK_COLOR_B: color_b_in    = csr_wdata[2:0];
            CSR_UPDATE_PERIOD: begin
               if (csr_wdata < PERIOD_LIMIT) begin
                  period_in = csr_wdata;
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer: tick counting, update latch and frame streaming
   always_comb begin
      state_in    = state_ff;
      tick_in     = tick_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      upd_mode_in = upd_mode_ff;
      upd_code_in = upd_code_ff;
      upd_pos_in  = upd_pos_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_advance) begin
               if (do_update) begin
                  tick_in     = '0;
                  idx_in      = '0;
                  upd_mode_in = mode_ff;
                  upd_pos_in  = '0;
                  state_in    = ST_EMIT;
                  unique case (mode_ff)
                     MODE_CONST: upd_code_in = main_color_ff;
                     MODE_BLINK: begin
                        if (phase_ff == phase_type'(1)) begin
                           upd_code_in = color_a_ff;
                           phase_in    = '0;
                        end else begin
                           upd_code_in = color_b_ff;
                           phase_in    = phase_type'(1);
                        end
                     end
                     MODE_WAVE: begin
                        upd_code_in = main_color_ff;
                        upd_pos_in  = wave_pos;
                        phase_in    = wave_pos + phase_type'(1);
                     end
                     MODE_STOP: upd_code_in = CODE_BLACK;
                     default:   upd_code_in = CODE_BLACK;
                  endcase
               end else begin
                  tick_in = tick_ff + TICK_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_word_in  = new_word;
               rsp_last_in  = idx_is_last;
               idx_in       = idx_ff + led_idx_type'(1);
               if (idx_is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, configuration, frame store and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_CONST;
         main_color_ff <= CODE_WHITE;
         color_a_ff    <= CODE_WHITE;
         color_b_ff    <= CODE_BLACK;
         period_ff     <= PERIOD_RESET;
         tick_ff       <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         for (int i = 0; i < LED_COUNT; i++) begin
            frame_ff[i] <= GRB_WHITE;
         end
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         main_color_ff <= main_color_in;
         color_a_ff    <= color_a_in;
         color_b_ff    <= color_b_in;
         period_ff     <= period_in;
         tick_ff       <= tick_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         if (load) begin
            frame_ff[idx_ff] <= new_word;
         end
      end
      upd_mode_ff <= upd_mode_in;
      upd_code_ff <= upd_code_in;
      upd_pos_ff  <= upd_pos_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = 3'(rsp_idx_ff);
   assign rsp_grb_word  = rsp_word_ff;
   assign rsp_last      = rsp_last_ff;

   // last marks exactly the final LED of the frame
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_idx_ff == led_idx_type'(LED_COUNT - 1))))
      else $error("last flag does not match LED index");

   // an update beat starts streaming at the first LED
   a_update_starts : assert property (@(posedge clock) disable iff (reset)
      do_update |=> (state_ff == ST_EMIT) && (idx_ff == '0) && (tick_ff == '0))
      else $error("update did not start the frame");

   // a tick without update counts up by one
   a_tick_count : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_advance && !do_update) |=> (tick_ff == $past(tick_ff) + TICK_W'(1)))
      else $error("tick counter did not advance");

   // the tick counter never passes the period limit
   a_tick_range : assert property (@(posedge clock) disable iff (reset)
      tick_ff < PERIOD_LIMIT)
      else $error("tick counter out of range");

   // a waiting word is not overwritten while stalled
   a_hold_word : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall) |=> $stable(idx_ff))
      else $error("sequencer advanced under stall");

endmodule

### verif/led_strip_pattern_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_strip_pattern_checker
// Watches the tick, word and configuration ports of the LED strip pattern
// sequencer, keeps its own copy of the frame store, phase, tick counter and
// registers, predicts the GRB words of every update and compares each word
// beat in order against the oldest prediction.
// ---------------------------------------------------------------------------
module led_strip_pattern_checker
   import lsps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_advance,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [2:0]            rsp_led_index,
   input  logic [23:0]           rsp_grb_word,
   input  logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    words_pending
);

   typedef struct packed {
      led_idx_type led_index;
      grb_type     grb_word;
      logic        last;
   } led_beat_type;

   // words still owed by the block, oldest first
   led_beat_type expected_beats[$];

   // shadow state
   grb_type             frame[LED_COUNT];
   phase_type           phase;
   logic [TICK_W-1:0]   tick_count;

   // shadow registers
   mode_type            mode;
   color_code_type      main_color;
   color_code_type      color_a;
   color_code_type      color_b;
   logic [TICK_W-1:0]   period;

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   // colour code to GRB word, green high, red middle, blue low
   function automatic grb_type palette_grb(input color_code_type code);
      grb_type word;
      case (code)
         CODE_WHITE: word = GRB_WHITE;
         CODE_BLUE:  word = 24'h0000FF;
         CODE_RED:   word = 24'h00FF00;
         CODE_GREEN: word = 24'hFF0000;
         default:    word = GRB_BLACK;
      endcase
      return word;
   endfunction

   // paint every LED; codes without a palette entry leave the strip alone
   task automatic fill_strip(input color_code_type code);
      if (code <= CODE_GREEN) begin
         for (int i = 0; i < LED_COUNT; i++) frame[i] = palette_grb(code);
      end
   endtask

   // one pattern step by mode
   task automatic repaint_frame();
      case (mode)
         MODE_CONST: begin
            fill_strip(main_color);
         end
         MODE_BLINK: begin
            if (phase == phase_type'(1)) begin
               fill_strip(color_a);
               phase = '0;
            end else begin
               fill_strip(color_b);
               phase = phase_type'(1);
            end
         end
         MODE_WAVE: begin
            // a position left over past the strip restarts at the first LED
            if (phase >= LED_COUNT) phase = '0;
            for (int i = 0; i < LED_COUNT; i++) frame[i] = GRB_BLACK;
            if (main_color <= CODE_GREEN)
               frame[phase[LED_IDX_W-1:0]] = palette_grb(main_color);
            phase = phase + 1'b1;
         end
         default: begin
            fill_strip(CODE_BLACK);
         end
      endcase
   endtask

   // one millisecond tick; an update owes a full frame of words
   task automatic count_tick();
      if (tick_count >= period) begin
         tick_count = '0;
         repaint_frame();
         for (int i = 0; i < LED_COUNT; i++) begin
            expected_beats.push_back('{led_index: led_idx_type'(i),
                                       grb_word:  frame[i],
                                       last:      (i == LED_COUNT - 1)});
         end
      end else begin
         tick_count = tick_count + 1'b1;
      end
   endtask

   // register write, period writes at or past the limit are dropped
   task automatic apply_csr_write();
      case (csr_index)
         CSR_PATTERN_MODE:  mode       = mode_type'(csr_wdata[1:0]);
         CSR_MAIN_COLOR:    main_color = csr_wdata[2:0];
         CSR_BLINK_COLOR_A: color_a    = csr_wdata[2:0];
         CSR_BLINK_COLOR_B: color_b    = csr_wdata[2:0];
         CSR_UPDATE_PERIOD: begin
            if (csr_wdata < PERIOD_LIMIT) period = csr_wdata;
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string what, input led_beat_type want,
                                input led_beat_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch, %s: expected idx %0d grb %06h last %0b, got idx %0d grb %06h last %0b",
                  $realtime, what, want.led_index, want.grb_word, want.last,
                  got.led_index, got.grb_word, got.last);
   endtask

   // sample everything at the rising edge
   always @(posedge clock) begin
      led_beat_type got;
      led_beat_type want;
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) frame[i] = GRB_WHITE;
         phase      = '0;
         tick_count = '0;
         mode       = MODE_CONST;
         main_color = CODE_WHITE;
         color_a    = CODE_WHITE;
         color_b    = CODE_BLACK;
         period     = PERIOD_RESET;
         expected_beats.delete();
      end else begin
         // a tick in the same cycle as a write still sees the old registers
         if (req_valid && !req_stall && req_advance) count_tick();
         if (csr_wr_en) apply_csr_write();
         // word beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = '{led_index: rsp_led_index, grb_word: rsp_grb_word, last: rsp_last};
            if (expected_beats.size() == 0) begin
               note_mismatch("word with none owed", '0, got);
            end else begin
               want = expected_beats.pop_front();
               if (got.led_index !== want.led_index || got.grb_word !== want.grb_word ||
                   got.last !== want.last)
                  note_mismatch("word differs", want, got);
            end
         end
      end
      words_pending = expected_beats.size();
   end

endmodule

### verif/tb_led_strip_pattern_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_led_strip_pattern_sequencer
// Drives millisecond ticks and register writes into the LED strip pattern
// sequencer: a directed pass over every mode, off-palette colours, period
// corner cases and wave wrap, then random settings with short periods, and
// a last pass at the longest period. Both channels idle at random; the
// checker beside the block predicts and compares every word beat.
// ---------------------------------------------------------------------------
module tb_led_strip_pattern_sequencer;
   import lsps_pkg::*;

   localparam int RANDOM_TICKS = 250;
   localparam int LONG_TICKS = 12;
   localparam int SETTLE_CYCLES = LED_COUNT + 4;
   localparam color_code_type CODE_SPARE_LO = 3'd5;
   localparam color_code_type CODE_SPARE_HI = 3'd7;
   localparam logic [CSR_DATA_W-1:0] PERIOD_WRITE_MAX = '1;
   localparam logic [CSR_IDX_W-1:0]  CSR_INDEX_MAX = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_advance;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_led_index;
   logic [23:0]           rsp_grb_word;
   logic                  rsp_last;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    words_pending;
   bit                    quiet_run = 1'b0;

   led_strip_pattern_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_advance   (req_advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_index (rsp_led_index),
      .rsp_grb_word  (rsp_grb_word),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   led_strip_pattern_checker word_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_advance    (req_advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_index  (rsp_led_index),
      .rsp_grb_word   (rsp_grb_word),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // word side back-pressure in bursts, long clear stretches in between
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(40, 120)) @(negedge clock);
         else
            repeat ($urandom_range(1, 10)) @(negedge clock);
         if (!quiet_run && $urandom_range(0, 2) != 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // one register write, called at a falling edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
   endtask

   // one tick beat, with an optional gap in front
   task automatic send_tick(input logic adv);
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_advance = adv;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid   = 1'b0;
      req_advance = 1'b0;
   endtask

   // wait for all owed words, then let the sequencer go idle
   task automatic settle();
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random register settings, mostly short periods
   task automatic pick_settings();
      logic [CSR_DATA_W-1:0] period_value;
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_csr(CSR_MAIN_COLOR, CSR_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_csr(CSR_BLINK_COLOR_A, CSR_DATA_W'($urandom));
      if ($urandom_range(0, 2) != 0) write_csr(CSR_BLINK_COLOR_B, CSR_DATA_W'($urandom));
      case ($urandom_range(0, 7))
         0:       period_value = CSR_DATA_W'($urandom_range(PERIOD_LIMIT, PERIOD_WRITE_MAX));
         1:       period_value = CSR_DATA_W'($urandom_range(4, 12));
         default: period_value = CSR_DATA_W'($urandom_range(0, 3));
      endcase
      write_csr(CSR_UPDATE_PERIOD, period_value);
      if ($urandom_range(0, 5) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_UPDATE_PERIOD + 1, CSR_INDEX_MAX)),
                   CSR_DATA_W'($urandom));
   endtask

   initial begin
      int   tick_total;
      logic adv;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_advance = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      // constant green on every tick, plus a no-op beat
      write_csr(CSR_UPDATE_PERIOD, '0);
      write_csr(CSR_MAIN_COLOR, CSR_DATA_W'(CODE_GREEN));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_CONST));
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      // blink between red and blue
      write_csr(CSR_BLINK_COLOR_A, CSR_DATA_W'(CODE_RED));
      write_csr(CSR_BLINK_COLOR_B, CSR_DATA_W'(CODE_BLUE));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_BLINK));
      repeat (3) send_tick(1'b1);
      settle();

      // off-palette main colour keeps the previous frame
      write_csr(CSR_MAIN_COLOR, CSR_DATA_W'(CODE_SPARE_HI));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_CONST));
      send_tick(1'b1);
      settle();

      // wave across the strip and wrap back to the first LED
      write_csr(CSR_MAIN_COLOR, CSR_DATA_W'(CODE_BLUE));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_WAVE));
      repeat (LED_COUNT + 1) send_tick(1'b1);
      settle();

      // blink picks up the phase the wave left behind
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_BLINK));
      send_tick(1'b1);
      settle();

      // wave with an off-palette colour blanks the strip
      write_csr(CSR_MAIN_COLOR, CSR_DATA_W'(CODE_SPARE_LO));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_WAVE));
      send_tick(1'b1);
      settle();

      // stop mode; out-of-range period writes and unused indexes do nothing
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_STOP));
      write_csr(CSR_UPDATE_PERIOD, PERIOD_WRITE_MAX);
      write_csr(CSR_UPDATE_PERIOD, PERIOD_LIMIT);
      write_csr(CSR_INDEX_MAX, PERIOD_WRITE_MAX);
      send_tick(1'b1);
      settle();

      // period lowered below the running count updates on the next tick
      write_csr(CSR_UPDATE_PERIOD, 10'd5);
      repeat (3) send_tick(1'b1);
      settle();
      write_csr(CSR_UPDATE_PERIOD, 10'd1);
      send_tick(1'b1);
      settle();

      // random settings and tick bursts, quiet toward the end
      tick_total = 0;
      while (tick_total < RANDOM_TICKS) begin
         settle();
         pick_settings();
         repeat ($urandom_range(8, 40)) begin
            adv = ($urandom_range(0, 6) != 0);
            send_tick(adv);
            tick_total++;
         end
         if (tick_total > RANDOM_TICKS * 3 / 4) quiet_run = 1'b1;
      end
      settle();

      // longest period: a stretch of ticks with no update, then a lowered
      // period fires on the next tick
      quiet_run = 1'b1;
      write_csr(CSR_UPDATE_PERIOD, PERIOD_RESET);
      write_csr(CSR_MAIN_COLOR, CSR_DATA_W'(CODE_RED));
      write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(MODE_CONST));
      repeat (LONG_TICKS) send_tick(1'b1);
      write_csr(CSR_UPDATE_PERIOD, 10'd1);
      send_tick(1'b1);

      // drain and verdict
      while (words_pending != 0) @(negedge clock);
      repeat (4 * LED_COUNT) @(negedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### led_strip_pattern_sequencer.f
design/lsps_pkg.sv
design/led_strip_pattern_sequencer.sv
verif/led_strip_pattern_checker.sv
verif/tb_led_strip_pattern_sequencer.sv
